FILE: sv/json_array_object_splitter_top_assert.svh
// ----------------------------------------------------------------------------
// JSON array splitter assertion macros
// Short forms for the clocked, reset-qualified properties in the checker.
// ----------------------------------------------------------------------------
`ifndef JSON_ARRAY_OBJECT_SPLITTER_TOP_ASSERT_SVH
`define JSON_ARRAY_OBJECT_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define JAOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splitter check failed");

// Next-cycle implication, checked while out of reset.
`define JAOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splitter check failed");

`endif

FILE: sv/jaos_pkg.sv
// ----------------------------------------------------------------------------
// JSON array splitter package
// Shared codes, characters and beat types.
// ----------------------------------------------------------------------------
package jaos_pkg;

  typedef enum logic [2:0] {
    ST_SKIP  = 3'd0,
    ST_BYTE  = 3'd1,
    ST_LAST  = 3'd2,
    ST_DONE  = 3'd3,
    ST_ERROR = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_UNEXPECTED = 3'd1,
    CAUSE_LONG       = 3'd2,
    CAUSE_DEEP       = 3'd3,
    CAUSE_EARLY      = 3'd4,
    CAUSE_EARLIER    = 3'd5
  } cause_t;

  // Configuration register indexes
  localparam logic REG_LENGTH_LIMIT = 1'b0;
  localparam logic REG_DEPTH_LIMIT  = 1'b1;

  localparam logic [9:0] LENGTH_LIMIT_RST = 10'd639;
  localparam logic [3:0] DEPTH_LIMIT_RST  = 4'd8;

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  typedef struct packed {
    logic       op;       // 1: end of stream
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic [15:0] object_number;
    cause_t      error_cause;
  } res_t;

endpackage

FILE: sv/jaos_in_stage.sv
// ----------------------------------------------------------------------------
// JSON array splitter input stage
// Registers one input beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module jaos_in_stage import jaos_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || take;
  assign valid    = valid_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: sv/jaos_core.sv
// ----------------------------------------------------------------------------
// JSON array splitter core
// Parse state, limits and the per-byte step from held beat to result.
// ----------------------------------------------------------------------------
module jaos_core import jaos_pkg::*; #(
  parameter int MAX_OBJECT_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [9:0] cfg_wdata,
  input  item_t      item,
  input  logic       advance,
  output res_t       res
);

  localparam int OBW = $clog2(MAX_OBJECT_BYTES);
  localparam int CW  = (OBW > 10) ? OBW : 10;
  localparam logic [CW-1:0] CAP_MAX = CW'(MAX_OBJECT_BYTES - 1);

  typedef enum logic [2:0] {
    PH_OPEN, PH_FIRST, PH_OBJECT, PH_AFTER, PH_NEXT, PH_END, PH_DONE, PH_ERROR
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [3:0]     depth_r, depth_nxt;
  logic           quote_r, quote_nxt;
  logic           bslash_r, bslash_nxt;
  logic [OBW-1:0] obytes_r, obytes_nxt;
  logic [15:0]    seen_r, seen_nxt;
  logic [9:0]     len_limit_r;
  logic [3:0]     depth_limit_r;

  logic [CW-1:0]  limit_ext, cap, obytes_ext;
  logic [7:0]     c;
  logic           blank, do_fail, start;
  cause_t         fail_cause;

  assign c          = item.in_byte;
  assign limit_ext  = CW'(len_limit_r);
  assign cap        = (limit_ext > CAP_MAX) ? CAP_MAX : limit_ext;
  assign obytes_ext = CW'(obytes_r);
  assign blank      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

  always_comb begin
    phase_nxt  = phase_r;
    depth_nxt  = depth_r;
    quote_nxt  = quote_r;
    bslash_nxt = bslash_r;
    obytes_nxt = obytes_r;
    seen_nxt   = seen_r;
    do_fail    = 1'b0;
    fail_cause = CAUSE_UNEXPECTED;
    start      = 1'b0;
    res.status        = ST_SKIP;
    res.out_byte      = 8'd0;
    res.object_number = seen_r;
    res.error_cause   = CAUSE_NONE;

    if (phase_r == PH_ERROR) begin
      res.status      = ST_ERROR;
      res.error_cause = CAUSE_EARLIER;
    end else if (phase_r == PH_DONE) begin
      if (item.op) begin
        res.status = ST_DONE;
      end else begin
        do_fail = 1'b1;
      end
    end else if (item.op) begin
      if (phase_r == PH_END) begin
        phase_nxt  = PH_DONE;
        res.status = ST_DONE;
      end else begin
        do_fail    = 1'b1;
        fail_cause = CAUSE_EARLY;
      end
    end else if (phase_r == PH_OBJECT) begin
      if (obytes_ext >= cap) begin
        do_fail    = 1'b1;
        fail_cause = CAUSE_LONG;
      end else begin
        obytes_nxt   = obytes_r + 1'b1;
        res.status   = ST_BYTE;
        res.out_byte = c;
        if (quote_r) begin
          if (bslash_r) begin
            bslash_nxt = 1'b0;
          end else if (c == CH_BSLASH) begin
            bslash_nxt = 1'b1;
          end else if (c == CH_QUOTE) begin
            quote_nxt = 1'b0;
          end
        end else if (c == CH_QUOTE) begin
          quote_nxt = 1'b1;
        end else if ((c == CH_LBRACE) || (c == CH_LBRACK)) begin
          if (({1'b0, depth_r} + 5'd1) > {1'b0, depth_limit_r}) begin
            do_fail    = 1'b1;
            fail_cause = CAUSE_DEEP;
          end else begin
            depth_nxt = depth_r + 4'd1;
          end
        end else if ((c == CH_RBRACE) || (c == CH_RBRACK)) begin
          depth_nxt = depth_r - 4'd1;
          if (depth_r == 4'd1) begin
            res.status = ST_LAST;
            phase_nxt  = PH_AFTER;
            if (seen_r != 16'hFFFF) begin
              seen_nxt = seen_r + 16'd1;
            end
          end
        end
      end
    end else if (!blank) begin
      case (phase_r)
        PH_OPEN: begin
          if (c == CH_LBRACK) begin
            phase_nxt = PH_FIRST;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_FIRST: begin
          if (c == CH_LBRACE) begin
            start = 1'b1;
          end else if (c == CH_RBRACK) begin
            phase_nxt = PH_END;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_AFTER: begin
          if (c == CH_COMMA) begin
            phase_nxt = PH_NEXT;
          end else if (c == CH_RBRACK) begin
            phase_nxt = PH_END;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_NEXT: begin
          if (c == CH_LBRACE) begin
            start = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        default: begin
          do_fail = 1'b1;
        end
      endcase
    end

    if (start) begin
      phase_nxt    = PH_OBJECT;
      depth_nxt    = 4'd1;
      quote_nxt    = 1'b0;
      bslash_nxt   = 1'b0;
      obytes_nxt   = OBW'(1);
      res.status   = ST_BYTE;
      res.out_byte = CH_LBRACE;
    end

    if (do_fail) begin
      phase_nxt       = PH_ERROR;
      res.status      = ST_ERROR;
      res.out_byte    = 8'd0;
      res.error_cause = fail_cause;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OPEN;
      depth_r       <= 4'd0;
      quote_r       <= 1'b0;
      bslash_r      <= 1'b0;
      obytes_r      <= '0;
      seen_r        <= 16'd0;
      len_limit_r   <= LENGTH_LIMIT_RST;
      depth_limit_r <= DEPTH_LIMIT_RST;
    end else begin
      if (advance) begin
        phase_r  <= phase_nxt;
        depth_r  <= depth_nxt;
        quote_r  <= quote_nxt;
        bslash_r <= bslash_nxt;
        obytes_r <= obytes_nxt;
        seen_r   <= seen_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_LENGTH_LIMIT: len_limit_r   <= cfg_wdata;
          REG_DEPTH_LIMIT:  depth_limit_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/jaos_out_stage.sv
// ----------------------------------------------------------------------------
// JSON array splitter output stage
// Result register that holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module jaos_out_stage import jaos_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load_valid,
  output logic load_ready,
  input  res_t load_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

FILE: sv/json_array_object_splitter_top.sv
// ----------------------------------------------------------------------------
// JSON array object splitter
// Splits a byte stream holding one JSON array of objects into object bytes,
// marks the closing byte of each object and flags malformed input.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / data           | tuser / index
//  in_     | slave     | in_byte                | op (1 = end of stream)
//  out_    | master    | out_byte, object_number, error_cause | status
//  cfg_    | write     | register value (10 b)  | cfg_index: register number
//
// One beat per cycle sustained while out_ is not stalled; each beat passes
// the input register, then the result register after one step of logic.
// The parse state feeds back only into the single step, so back-to-back
// beats never wait. Reset (rst_n low, synchronous) empties both registers
// and returns the parser to "expect opening bracket" with the default limits.
// A stall on out_ holds the result; in_tready then drops once the input
// register is also full. cfg_ is always ready.
// ----------------------------------------------------------------------------
module json_array_object_splitter_top import jaos_pkg::*; #(
  parameter int MAX_OBJECT_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [23:8] object_number,
                                  // [26:24] error_cause, [31:27] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  item_t in_item, held_item;
  logic  held_valid;
  logic  load_ready;
  logic  advance;
  res_t  step_res, out_res;

  assign in_item.op      = in_tuser;
  assign in_item.in_byte = in_tdata;

  // Consume the held beat whenever the result register can take it.
  assign advance   = held_valid && load_ready;
  assign cfg_ready = 1'b1;

  jaos_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (advance),
    .valid    (held_valid),
    .item     (held_item)
  );

  jaos_core #(
    .MAX_OBJECT_BYTES (MAX_OBJECT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .item      (held_item),
    .advance   (advance),
    .res       (step_res)
  );

  jaos_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (held_valid),
    .load_ready (load_ready),
    .load_res   (step_res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Pack result fields, lowest first; pad to whole bytes.
  assign out_tdata = {5'd0, out_res.error_cause, out_res.object_number, out_res.out_byte};
  assign out_tuser = out_res.status;

endmodule

FILE: sv/jaos_checker.sv
// ----------------------------------------------------------------------------
// JSON array splitter checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_array_object_splitter_top_assert.svh"

module jaos_checker import jaos_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // Hold a stalled result beat.
  `JAOS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Error cause only accompanies an error beat.
  `JAOS_ASSERT_NOW(a_cause_only_on_error, clk, rst_n, out_tvalid && (out_tuser != ST_ERROR), out_tdata[26:24] == CAUSE_NONE)

  // Byte field is zero unless an object byte is passed.
  `JAOS_ASSERT_NOW(a_byte_only_in_object, clk, rst_n, out_tvalid && (out_tuser != ST_BYTE) && (out_tuser != ST_LAST), out_tdata[7:0] == 8'd0)

  // The closing beat of an object carries a closing bracket.
  `JAOS_ASSERT_NOW(a_last_is_closer, clk, rst_n, out_tvalid && (out_tuser == ST_LAST), (out_tdata[7:0] == CH_RBRACE) || (out_tdata[7:0] == CH_RBRACK))

endmodule

bind json_array_object_splitter_top jaos_checker u_jaos_checker (.*);
